>>> rtl/core/pcfu_pkg.sv
// Package for the palette color fade unit: mode codes, channel constants and
// the stage-advance struct shared by the top level and the channel lane.
// It depends on nothing else.
`default_nettype none

package pcfu_pkg;

   localparam int unsigned CHANNEL_WIDTH = 8;
   localparam int unsigned AMOUNT_WIDTH  = 9;
   localparam int unsigned PRODUCT_WIDTH = CHANNEL_WIDTH + AMOUNT_WIDTH;
   localparam int unsigned SQUARE_WIDTH  = 2 * CHANNEL_WIDTH;
   localparam int unsigned PACKED_WIDTH  = 5;
   localparam int unsigned INDEX_WIDTH   = 9;
   localparam int unsigned REQ_WIDTH     = 72;
   localparam int unsigned RSP_WIDTH     = 24;

   localparam logic [AMOUNT_WIDTH-1:0]  FULL_AMOUNT = 9'd256;
   localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_MAX = 8'd255;

   typedef enum logic [2:0] {
      OP_PASS       = 3'd0,
      OP_BRIGHTNESS = 3'd1,
      OP_BLEND      = 3'd2,
      OP_FADE       = 3'd3,
      OP_TINT       = 3'd4,
      OP_MODULATE   = 3'd5
   } op_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } adv_type;

endpackage

`default_nettype wire

>>> rtl/core/pcfu_lane.sv
// One color channel of the fade datapath: amount products, the second
// product for tint and modulate, and the exact division by 255.
// It depends on pcfu_pkg.
`default_nettype none

module pcfu_lane (
   input  wire                                     clock,
   input  pcfu_pkg::adv_type                       adv,
   input  pcfu_pkg::op_type                        op_in,
   input  wire  [pcfu_pkg::AMOUNT_WIDTH-1:0]       amount_in,
   input  wire  [pcfu_pkg::CHANNEL_WIDTH-1:0]      base_in,
   input  wire  [pcfu_pkg::CHANNEL_WIDTH-1:0]      fade_in,
   input  pcfu_pkg::op_type                        op_s1,
   input  pcfu_pkg::op_type                        op_s2,
   output logic [pcfu_pkg::PACKED_WIDTH-1:0]       channel_out
);

   logic [pcfu_pkg::CHANNEL_WIDTH-1:0]   scale_src;
   logic [pcfu_pkg::PRODUCT_WIDTH-1:0]   m1_in, m2_in, m1_ff, m2_ff;
   logic [pcfu_pkg::CHANNEL_WIDTH-1:0]   base_s1_ff, fade_s1_ff;
   logic [pcfu_pkg::PRODUCT_WIDTH-1:0]   mix_sum;
   logic [pcfu_pkg::CHANNEL_WIDTH-1:0]   t_val;
   logic [pcfu_pkg::SQUARE_WIDTH-1:0]    q_in, q_ff;
   logic [pcfu_pkg::SQUARE_WIDTH:0]      div_sum;
   logic [pcfu_pkg::CHANNEL_WIDTH-1:0]   value;

   always_comb begin
      case (op_in)
         pcfu_pkg::OP_FADE, pcfu_pkg::OP_MODULATE: scale_src = fade_in;
         pcfu_pkg::OP_TINT: scale_src = pcfu_pkg::CHANNEL_MAX - fade_in;
         default: scale_src = base_in;
      endcase
   end

   assign m1_in = {9'd0, scale_src} * {8'd0, amount_in};
   assign m2_in = (op_in == pcfu_pkg::OP_BLEND) ?
                  {9'd0, fade_in} * {8'd0, pcfu_pkg::FULL_AMOUNT - amount_in} :
                  '0;

   always_ff @(posedge clock) begin
      if (adv.s1_load) begin
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         base_s1_ff <= base_in;
         fade_s1_ff <= fade_in;
      end
   end

   assign mix_sum = m1_ff + m2_ff;

   always_comb begin
      t_val = m1_ff[15:8];
      q_in  = {8'd0, mix_sum[15:8]};
      case (op_s1)
         pcfu_pkg::OP_BRIGHTNESS, pcfu_pkg::OP_BLEND, pcfu_pkg::OP_FADE: begin
            q_in = {8'd0, mix_sum[15:8]};
         end
         pcfu_pkg::OP_TINT: begin
            t_val = fade_s1_ff + m1_ff[15:8];
            q_in  = {8'd0, t_val} * {8'd0, base_s1_ff};
         end
         pcfu_pkg::OP_MODULATE: begin
            q_in = {8'd0, t_val} * {8'd0, base_s1_ff};
         end
         default: begin
            q_in = {8'd0, base_s1_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv.s2_load) begin
         q_ff <= q_in;
      end
   end

   // Exact q / 255 for q below 65535 as (q + q/256 + 1) / 256.
   assign div_sum = {1'b0, q_ff} + {9'd0, q_ff[15:8]} + 17'd1;
   assign value   = (op_s2 == pcfu_pkg::OP_TINT || op_s2 == pcfu_pkg::OP_MODULATE) ?
                    div_sum[15:8] : q_ff[7:0];
   assign channel_out = value[7:3];

endmodule

`default_nettype wire

>>> rtl/core/palette_color_fade_unit_core.sv
// Top level of the palette color fade unit: handshake, valid pipeline and
// output register around three channel lanes.
// It depends on pcfu_pkg and pcfu_lane.
//
//   Channel  Direction  Payload
//   req      in         mode, amount, base RGB888, fade RGB888, color index
//   rsp      out        packed RGB555 color, destination index
//
// An item passes three register stages (the lane products, the lane results
// before division and the output color register) before rsp carries it.
// One item is accepted per cycle while the result side keeps taking items.
// Reset clears the stage valid bits only; the data registers are not reset.
// Each stage moves when it is empty or the stage after it moves, so a stall
// fills the pipeline without losing or repeating an item.
`default_nettype none

module palette_color_fade_unit_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // opcode[2:0], amount[11:3], base_red[19:12], base_green[27:20],
   // base_blue[35:28], fade_red[43:36], fade_green[51:44], fade_blue[59:52],
   // color_index[68:60], zero fill [71:69]
   input  wire  [pcfu_pkg::REQ_WIDTH-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // packed_color[14:0], dest_index[23:15]
   output logic [pcfu_pkg::RSP_WIDTH-1:0] rsp_tdata
);

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   pcfu_pkg::adv_type adv;
   pcfu_pkg::op_type  op_in, op_s1_ff, op_s2_ff;
   logic [pcfu_pkg::AMOUNT_WIDTH-1:0] amount_sat;
   logic [pcfu_pkg::INDEX_WIDTH-1:0]  idx_s1_ff, idx_s2_ff, idx_s3_ff;
   logic [pcfu_pkg::PACKED_WIDTH-1:0] red5, green5, blue5;
   logic [14:0] color_ff;

   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign adv.s1_load = rdy1;
   assign adv.s2_load = rdy2;

   assign op_in      = pcfu_pkg::op_type'(req_tdata[2:0]);
   assign amount_sat = req_tdata[11] ? pcfu_pkg::FULL_AMOUNT : req_tdata[11:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         op_s1_ff  <= op_in;
         idx_s1_ff <= req_tdata[68:60];
      end
      if (rdy2) begin
         op_s2_ff  <= op_s1_ff;
         idx_s2_ff <= idx_s1_ff;
      end
      if (rdy3) begin
         color_ff  <= {blue5, green5, red5};
         idx_s3_ff <= idx_s2_ff;
      end
   end

   pcfu_lane u_red (
      .clock       (clock),
      .adv         (adv),
      .op_in       (op_in),
      .amount_in   (amount_sat),
      .base_in     (req_tdata[19:12]),
      .fade_in     (req_tdata[43:36]),
      .op_s1       (op_s1_ff),
      .op_s2       (op_s2_ff),
      .channel_out (red5)
   );

   pcfu_lane u_green (
      .clock       (clock),
      .adv         (adv),
      .op_in       (op_in),
      .amount_in   (amount_sat),
      .base_in     (req_tdata[27:20]),
      .fade_in     (req_tdata[51:44]),
      .op_s1       (op_s1_ff),
      .op_s2       (op_s2_ff),
      .channel_out (green5)
   );

   pcfu_lane u_blue (
      .clock       (clock),
      .adv         (adv),
      .op_in       (op_in),
      .amount_in   (amount_sat),
      .base_in     (req_tdata[35:28]),
      .fade_in     (req_tdata[59:52]),
      .op_s1       (op_s1_ff),
      .op_s2       (op_s2_ff),
      .channel_out (blue5)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {idx_s3_ff, color_ff};

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready)
      else $error("Input stalled while the first stage is empty.");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("Accepted item did not enter the first stage.");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      v1_ff && rdy2 |=> v2_ff)
      else $error("Item lost between the first and second stage.");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !v2_ff |=> !rsp_tvalid)
      else $error("Result repeated after it was taken.");

endmodule

`default_nettype wire
